// File: rtl/nfcf_pkg.sv
package nfcf_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// Field widths.
	localparam int CLUSTER_W  = 8;
	localparam int ENTRY_W    = 8;
	localparam int CPT_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Search walk widths: up to twice a 256-cluster span, positions may go negative.
	localparam int STEP_W = 10;
	localparam int POS_W  = 11;

	// Reset values of the configuration registers.
	localparam logic [CLUSTER_W-1:0] START_RESET  = 8'd64;
	localparam logic [CLUSTER_W-1:0] LAST_RESET   = 8'd159;
	localparam logic [CPT_W-1:0]     CPT_RESET    = 6'd4;
	localparam logic [ENTRY_W-1:0]   UNUSED_RESET = 8'hFF;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_FIND  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START  = 2'd0,
		REG_LAST   = 2'd1,
		REG_CPT    = 2'd2,
		REG_UNUSED = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	// Candidate presented by the search walk in the current cycle.
	typedef struct packed {
		logic             busy;
		logic             usable;
		logic             tail;
		logic [IDX_W-1:0] addr;
	} cand_t;

	typedef struct packed {
		logic                 found;
		logic [CLUSTER_W-1:0] cluster_number;
		logic [ENTRY_W-1:0]   entry_read;
	} result_t;

endpackage

// File: rtl/nfcf_in_if.sv
interface nfcf_in_if import nfcf_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic [1:0]           action;
	logic [CLUSTER_W-1:0] cluster_index;
	logic [ENTRY_W-1:0]   entry_value;

	modport source (output valid, action, cluster_index, entry_value, input ready);
	modport sink (input valid, action, cluster_index, entry_value, output ready);

endinterface

// File: rtl/nfcf_out_if.sv
interface nfcf_out_if import nfcf_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [CLUSTER_W-1:0] cluster_number;
	logic [ENTRY_W-1:0]   entry_read;

	modport source (output valid, found, cluster_number, entry_read, input ready);
	modport sink (input valid, found, cluster_number, entry_read, output ready);

endinterface

// File: rtl/nfcf_ram.sv
module nfcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/nfcf_table.sv
module nfcf_table import nfcf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [IDX_W-1:0]   waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic               re,
	input  logic [IDX_W-1:0]   raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [TABLE_DEPTH-1:0] written_q;
	logic                   written_s1;
	logic [ENTRY_W-1:0]     ram_rdata;

	nfcf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// One flag per entry; reset clears them all so every entry reads as the reset free code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			written_s1 <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				written_s1 <= written_q[raddr];
			end
		end
	end

	// An entry never written since reset holds the reset free code.
	assign rdata = written_s1 ? ram_rdata : UNUSED_RESET;

endmodule

// File: rtl/nfcf_walk.sv
module nfcf_walk import nfcf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic                 stop,
	input  logic [CLUSTER_W-1:0] start_cluster,
	input  logic [CLUSTER_W-1:0] last_cluster,
	input  logic [CPT_W-1:0]     clusters_per_track,
	output cand_t                cand
);

	localparam logic signed [POS_W-1:0] DEPTH_POS = POS_W'(TABLE_DEPTH);

	logic                    busy_q;
	logic [STEP_W-1:0]       step_q;
	logic [CPT_W-1:0]        off_q;
	logic                    odd_q;
	logic signed [POS_W-1:0] base_lo_q;
	logic signed [POS_W-1:0] base_hi_q;

	logic [CPT_W-1:0]        stride;
	logic signed [POS_W-1:0] stride_s;
	logic signed [POS_W-1:0] start_s;
	logic signed [POS_W-1:0] last_s;
	logic signed [POS_W-1:0] span_raw;
	logic signed [POS_W-1:0] span;
	logic [STEP_W-1:0]       steps_m1;
	logic signed [POS_W-1:0] pos;
	logic                    run_end;

	// Stride and number of steps follow from the configuration.
	always_comb begin
		stride    = (clusters_per_track == '0) ? CPT_W'(1) : clusters_per_track;
		stride_s  = $signed(POS_W'(stride));
		start_s   = $signed(POS_W'(start_cluster));
		last_s    = $signed(POS_W'(last_cluster));
		span_raw  = $signed(POS_W'(last_cluster) + POS_W'(1) - POS_W'(start_cluster));
		span      = (span_raw < start_s) ? start_s : span_raw;
		steps_m1  = STEP_W'({span, 1'b0} - (POS_W + 1)'(1));
	end

	// The current candidate: the run below the start on even runs, above it on odd runs.
	always_comb begin
		pos         = (odd_q ? base_hi_q : base_lo_q) + $signed(POS_W'(off_q));
		run_end     = (off_q == stride - CPT_W'(1));
		cand.busy   = busy_q;
		cand.usable = !pos[POS_W-1] && (pos <= last_s) && (pos < DEPTH_POS);
		cand.tail   = (step_q == steps_m1);
		cand.addr   = pos[IDX_W-1:0];
	end

	// Step through the runs, moving both bases one stride outward after each pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			off_q     <= '0;
			odd_q     <= 1'b0;
			base_lo_q <= '0;
			base_hi_q <= '0;
		end else if (go) begin
			busy_q    <= 1'b1;
			step_q    <= '0;
			off_q     <= '0;
			odd_q     <= 1'b0;
			base_lo_q <= start_s - stride_s;
			base_hi_q <= start_s;
		end else if (busy_q) begin
			if (stop || cand.tail) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q + STEP_W'(1);
			if (run_end) begin
				off_q <= '0;
				odd_q <= !odd_q;
				if (odd_q) begin
					base_lo_q <= base_lo_q - stride_s;
					base_hi_q <= base_hi_q + stride_s;
				end
			end else begin
				off_q <= off_q + CPT_W'(1);
			end
		end
	end

endmodule

// File: rtl/nearest_free_cluster_finder.sv
// One request at a time: a new request is taken only in idle, after the previous
// result has been registered for output. A write goes straight to the emit state; a
// read passes through the access state for its registered table read; a search walks
// outward from the start cluster, reads the table for each usable candidate, checks
// the entry read and stops on a free one or at its last step. Reset loads the register
// reset values and marks every table entry unwritten (reads as 0xFF) via per-entry flags.
module nearest_free_cluster_finder import nfcf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	nfcf_in_if.sink               req,
	nfcf_out_if.source            rsp,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [CLUSTER_W-1:0] start_q;
	logic [CLUSTER_W-1:0] last_q;
	logic [CPT_W-1:0]     cpt_q;
	logic [ENTRY_W-1:0]   unused_q;

	result_t res_q;
	result_t out_q;
	logic    out_vld_q;
	logic    rd_ok_q;

	logic             chk_vld_s1;
	logic             chk_tail_s1;
	logic [IDX_W-1:0] chk_addr_s1;

	action_t            act;
	logic               accepted;
	logic               idx_ok;
	logic               out_free;
	logic               hit;
	logic               tbl_we;
	logic               tbl_re;
	logic [IDX_W-1:0]   tbl_raddr;
	logic [ENTRY_W-1:0] tbl_rdata;
	logic               walk_go;
	logic               walk_stop;
	cand_t              cand;

	nfcf_table u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (tbl_we),
		.waddr (req.cluster_index[IDX_W-1:0]),
		.wdata (req.entry_value),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	nfcf_walk u_walk (
		.clk               (clk),
		.arst_n            (arst_n),
		.go                (walk_go),
		.stop              (walk_stop),
		.start_cluster     (start_q),
		.last_cluster      (last_q),
		.clusters_per_track(cpt_q),
		.cand              (cand)
	);

	// Request decode and status terms.
	always_comb begin
		act      = action_t'(req.action);
		accepted = req.valid && req.ready;
		idx_ok   = {1'b0, req.cluster_index} < (CLUSTER_W + 1)'(TABLE_DEPTH);
		out_free = !out_vld_q || rsp.ready;
		hit      = chk_vld_s1 && (tbl_rdata == unused_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accepted) begin
					case (act)
						ACT_READ: state_d = ST_ACCESS;
						ACT_FIND: state_d = ST_SEARCH;
						default:  state_d = ST_EMIT;
					endcase
				end
			end
			ST_ACCESS: state_d = ST_EMIT;
			ST_SEARCH: begin
				if (hit || chk_tail_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs: handshake, table port and walk control.
	always_comb begin
		req.ready = 1'b0;
		tbl_we    = 1'b0;
		tbl_re    = 1'b0;
		tbl_raddr = cand.addr;
		walk_go   = 1'b0;
		walk_stop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				tbl_raddr = req.cluster_index[IDX_W-1:0];
				tbl_we    = accepted && (act == ACT_WRITE) && idx_ok;
				tbl_re    = accepted && (act == ACT_READ) && idx_ok;
				walk_go   = accepted && (act == ACT_FIND);
			end
			ST_SEARCH: begin
				tbl_re    = cand.busy && cand.usable;
				walk_stop = hit;
			end
			default: begin
				tbl_re = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RESET;
			last_q   <= LAST_RESET;
			cpt_q    <= CPT_RESET;
			unused_q <= UNUSED_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_START:  start_q  <= cfg_data[CLUSTER_W-1:0];
				REG_LAST:   last_q   <= cfg_data[CLUSTER_W-1:0];
				REG_CPT:    cpt_q    <= cfg_data[CPT_W-1:0];
				REG_UNUSED: unused_q <= cfg_data[ENTRY_W-1:0];
				default:    start_q  <= start_q;
			endcase
		end
	end

	// State, check stage and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chk_vld_s1  <= 1'b0;
			chk_tail_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
			rd_ok_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			chk_vld_s1  <= cand.busy && cand.usable;
			chk_tail_s1 <= cand.busy && cand.tail;
			if (accepted) begin
				rd_ok_q <= idx_ok;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Result assembly and output register.
	always_ff @(posedge clk) begin
		chk_addr_s1 <= cand.addr;
		case (state_q)
			ST_IDLE: begin
				if (accepted) begin
					res_q <= '{
						found:          1'b0,
						cluster_number: (act == ACT_WRITE || act == ACT_READ) ?
						                req.cluster_index : '0,
						entry_read:     '0
					};
				end
			end
			ST_ACCESS: res_q.entry_read <= rd_ok_q ? tbl_rdata : '0;
			ST_SEARCH: begin
				if (hit) begin
					res_q <= '{
						found:          1'b1,
						cluster_number: CLUSTER_W'(chk_addr_s1),
						entry_read:     '0
					};
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: res_q <= res_q;
		endcase
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.found          = out_q.found;
	assign rsp.cluster_number = out_q.cluster_number;
	assign rsp.entry_read     = out_q.entry_read;

endmodule
